### src/hpesm_pkg.sv
package hpesm_pkg;

    typedef enum logic [2:0] {
        ST_DISC      = 3'd0,
        ST_WAIT_HOT  = 3'd1,
        ST_WAIT_WARM = 3'd2,
        ST_ENABLED   = 3'd3,
        ST_WAIT_LINK = 3'd4,
        ST_SUSPENDED = 3'd5,
        ST_WAIT_RES  = 3'd6
    } t_port_state;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_POFF = 2'd1,
        CMD_HOT  = 2'd2,
        CMD_WARM = 2'd3
    } t_port_cmd;

    // change flag bit positions
    localparam int CF_CONN   = 0;
    localparam int CF_ENABLE = 1;
    localparam int CF_SUSP   = 2;
    localparam int CF_OVC    = 3;
    localparam int CF_RESET  = 4;
    localparam int CF_BH     = 5;
    localparam int CF_LINK   = 6;
    localparam int CF_CFGERR = 7;

    localparam logic [7:0] ACK_ALWAYS = 8'h19;  // overcurrent, reset, connection
    localparam logic [7:0] ACK_SS     = 8'he0;  // bh reset, link, config error
    localparam logic [7:0] ACK_HS     = 8'h06;  // enable, suspend

    localparam logic [3:0] LINK_U0       = 4'd0;
    localparam logic [3:0] LINK_U3       = 4'd3;
    localparam logic [3:0] LINK_INACTIVE = 4'd6;

    localparam int PORT_W = 4;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic              in_range;
        logic              failed;
        logic              conn;
        logic              en_bit;
        logic [3:0]        link;
        logic [7:0]        chg;
    } t_event;

    typedef struct packed {
        logic              wr_en;
        logic              status_error;
        logic [7:0]        ack_mask;
        t_port_cmd         cmd;
        t_port_state       new_state;
        logic              start_enum;
    } t_result;

endpackage

### src/hub_port_event_state_machine_unit.sv
// Hub port event state machine. One item in is a decoded port status event, one item out
// is its result: change bits to acknowledge, a port command, the port's new state and a
// start-enumeration flag. Per-port states live in a small synchronous RAM; an item reads
// its entry in the cycle it is accepted; the result is computed, then written back as it
// moves into the output register, with a bypass when the following item hits the entry
// just written. The block takes one item per cycle and stalls only while the output
// register is full and not taken. After reset every port reads as disconnected
// (per-entry valid bits, no clearing pass). The user must write the superspeed_hub
// register over the cfg channel only while no item is in flight; the block doesn't check.
module hub_port_event_state_machine_unit import hpesm_pkg::*; #(
    parameter int MAX_PORTS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // cfg: superspeed_hub
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // port_index[3:0], connected[4], enabled_bit[5], link_state[9:6], change_flags[17:10]
    input  logic [23:0] s_axis_tdata,
    // read_failed[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // port_echo[3:0], ack_mask[11:4], port_command[13:12], new_state[16:14],
    // start_enumeration[17]
    output logic [23:0] m_axis_tdata,
    // status_error[0]
    output logic        m_axis_tuser
);

    localparam int TOP_PORT = (MAX_PORTS < 15) ? MAX_PORTS : 15;
    localparam int DEPTH    = TOP_PORT + 1;
    localparam int AW       = $clog2(DEPTH);
    localparam int CMP_W    = 9;

    logic                r_ss;
    logic                r_s1_valid;
    t_event              r_s1_evt;
    logic                r_s1_fwd;
    t_port_state         r_s1_fwd_st;
    logic                r_s1_vbit;
    logic [DEPTH-1:0]    r_vbits;
    logic                r_o_valid;
    logic [PORT_W-1:0]   r_o_port;
    t_result             r_o_res;

    t_event              in_evt;
    logic                accept;
    logic                s1_adv;
    logic                wr_en;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [2:0]          ram_q;
    t_port_state         cur_st;
    t_result             res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ss <= 1'b0;
        end else if (i_cfg_valid) begin
            r_ss <= i_cfg_data;
        end
    end

    always_comb begin
        in_evt.port     = s_axis_tdata[3:0];
        in_evt.conn     = s_axis_tdata[4];
        in_evt.en_bit   = s_axis_tdata[5];
        in_evt.link     = s_axis_tdata[9:6];
        in_evt.chg      = s_axis_tdata[17:10];
        in_evt.failed   = s_axis_tuser;
        in_evt.in_range = (s_axis_tdata[3:0] != '0) &&
                          (CMP_W'(s_axis_tdata[3:0]) <= CMP_W'(MAX_PORTS));
    end

    assign s1_adv        = r_s1_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign rd_addr       = s_axis_tdata[AW-1:0];
    assign wr_addr       = r_s1_evt.port[AW-1:0];
    assign wr_en         = s1_adv && res.wr_en;

    hpesm_ram #(
        .WIDTH (3),
        .DEPTH (DEPTH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (res.new_state),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // entry written in the cycle this item was read is newer than what the RAM returns
    always_comb begin
        if (r_s1_fwd) begin
            cur_st = r_s1_fwd_st;
        end else if (r_s1_vbit) begin
            cur_st = t_port_state'(ram_q);
        end else begin
            cur_st = ST_DISC;
        end
    end

    hpesm_next u_next (
        .i_evt (r_s1_evt),
        .i_ss  (r_ss),
        .i_cur (cur_st),
        .o_res (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_vbits    <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            if (wr_en) begin
                r_vbits[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_evt    <= in_evt;
            r_s1_fwd    <= wr_en && (wr_addr == rd_addr);
            r_s1_fwd_st <= res.new_state;
            r_s1_vbit   <= r_vbits[rd_addr];
        end
        if (s1_adv) begin
            r_o_port <= r_s1_evt.port;
            r_o_res  <= res;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_res.status_error;
    assign m_axis_tdata  = {6'b0, r_o_res.start_enum, r_o_res.new_state, r_o_res.cmd,
                            r_o_res.ack_mask, r_o_port};

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_valid && r_o_valid && !m_axis_tready))
        else $error("input stalled without a full pipeline");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted item lost before compute stage");

    a_enum_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[17]) |->
        (m_axis_tdata[16:14] == ST_ENABLED && !m_axis_tuser))
        else $error("enumeration start without enabled port");

    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata[11:4] == 8'h00 && m_axis_tdata[13:12] == CMD_NONE))
        else $error("failed status produced an ack or a command");

endmodule

### src/hpesm_ram.sv
module hpesm_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/hpesm_next.sv
module hpesm_next import hpesm_pkg::*; (
    input  t_event      i_evt,
    input  logic        i_ss,
    input  t_port_state i_cur,
    output t_result     o_res
);

    logic        up;
    t_port_state st;
    t_port_cmd   cmd;
    logic        start;
    logic [7:0]  ack;

    always_comb begin
        st    = i_cur;
        cmd   = CMD_NONE;
        start = 1'b0;
        ack   = (i_evt.chg & ACK_ALWAYS) | (i_evt.chg & (i_ss ? ACK_SS : ACK_HS));
        up    = i_ss ? (i_evt.link == LINK_U0) : i_evt.en_bit;

        if (i_evt.chg[CF_OVC]) begin
            cmd = CMD_POFF;
            st  = ST_DISC;
        end else if (i_evt.chg[CF_CONN] || (i_evt.conn && i_cur == ST_DISC)) begin
            if (!i_evt.conn) begin
                st = ST_DISC;
            end else if (i_ss && i_evt.link == LINK_INACTIVE) begin
                cmd = CMD_WARM;
                st  = ST_WAIT_WARM;
            end else begin
                cmd = CMD_HOT;
                st  = ST_WAIT_HOT;
            end
        end else if ((i_evt.chg[CF_RESET] || i_evt.chg[CF_BH]) &&
                     (i_cur == ST_WAIT_HOT || i_cur == ST_WAIT_WARM)) begin
            st    = up ? ST_ENABLED : ST_DISC;
            start = up;
        end else if (i_ss) begin
            if (i_evt.chg[CF_LINK]) begin
                if (i_cur == ST_WAIT_LINK) begin
                    st = (i_evt.link == LINK_U3) ? ST_SUSPENDED : ST_ENABLED;
                end else if (i_cur == ST_ENABLED && i_evt.link == LINK_INACTIVE) begin
                    cmd = CMD_WARM;
                    st  = ST_WAIT_WARM;
                end else if (i_cur == ST_SUSPENDED && i_evt.link == LINK_U0) begin
                    st = ST_ENABLED;
                end
            end
        end else begin
            // suspend wake goes first so a same-item enable change sees it
            if (i_evt.chg[CF_SUSP] && (i_cur == ST_WAIT_RES || i_cur == ST_SUSPENDED)) begin
                st = ST_ENABLED;
            end
            if (i_evt.chg[CF_ENABLE] && st == ST_ENABLED) begin
                cmd = CMD_HOT;
                st  = ST_WAIT_HOT;
            end
        end

        o_res.wr_en        = i_evt.in_range && !i_evt.failed;
        o_res.status_error = !o_res.wr_en;
        o_res.ack_mask     = o_res.wr_en ? ack : 8'h00;
        o_res.cmd          = o_res.wr_en ? cmd : CMD_NONE;
        o_res.start_enum   = o_res.wr_en && start;
        if (!i_evt.in_range) begin
            o_res.new_state = ST_DISC;
        end else if (i_evt.failed) begin
            o_res.new_state = i_cur;
        end else begin
            o_res.new_state = st;
        end
    end

endmodule
